[src/ntf_pkg.sv]
// types, codes and character constants shared by the number to text formatter
package ntf_pkg;

   // number formats carried in the request tuser
   typedef enum logic [1:0] {
      FMT_UNSIGNED_DEC = 2'd0,
      FMT_SIGNED_DEC   = 2'd1,
      FMT_HEX          = 2'd2,
      FMT_BIN          = 2'd3
   } fmt_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_CONVERT = 2'd1,
      ST_SIGN    = 2'd2,
      ST_EMIT    = 2'd3
   } state_type;

   // digit count limits per format
   localparam logic [5:0] MAX_DEC_DIGITS = 6'd10;
   localparam logic [5:0] MAX_HEX_DIGITS = 6'd8;
   localparam logic [5:0] MAX_BIN_DIGITS = 6'd32;

   // bcd register holds one nibble per decimal digit
   localparam int unsigned BCD_DIGITS = 10;
   localparam int unsigned BCD_WIDTH  = 4 * BCD_DIGITS;

   // ascii codes
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_PLUS  = 7'h2B;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;

   // ascii code of one digit value, 0..9 then A..F
   function automatic logic [6:0] digit_char(input logic [3:0] digit);
      logic [6:0] code;
      if (digit < 4'd10) begin
         code = CHAR_ZERO + {3'b000, digit};
      end else begin
         code = CHAR_UPPER_A + {3'b000, digit} - 7'd10;
      end
      return code;
   endfunction

endpackage

[src/number_to_text_formatter.sv]
// number to text formatter: binary value to ascii digits placed on a text screen
//
// channel  dir  tdata (low bit up)                                   side band
// req      in   number[31:0] digit_count[37:32] row[40:38]
//               first_column[45:41] zero pad[47:46]                  tuser = operation
// rsp      out  out_row[2:0] out_column[7:3] char_code[14:8]
//               zero pad[15]                                         tlast = last_char
//
// hex and binary emit their digits directly; decimal first runs 32 shift-and-add-3 steps,
// one bit per cycle, and signed decimal puts a sign before its digits.
// one transaction is worked at a time; req_tready is high only while idle.
// a transaction on a row off the screen, or hex or binary with no digits, is accepted and the sequencer stays idle.
// reset clears the sequencer and the result valid, no clearing pass.
// rsp_tready low while a result is waiting holds the result register and stalls character generation.
module number_to_text_formatter
   import ntf_pkg::*;
#(
   parameter int TEXT_ROWS    = 4,
   parameter int TEXT_COLUMNS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // number, digit_count, row, first_column
   input  logic [1:0]  req_tuser,   // operation
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_row, out_column, char_code
   output logic        rsp_tlast    // last_char
);

   localparam logic [3:0] ROW_LIMIT = 4'(TEXT_ROWS);
   localparam logic [5:0] COL_LIMIT = 6'(TEXT_COLUMNS);

   // request fields
   logic [31:0] req_number;
   logic [5:0]  req_digit_count;
   logic [2:0]  req_row;
   logic [4:0]  req_first_column;
   fmt_type     req_fmt;

   assign req_number       = req_tdata[31:0];
   assign req_digit_count  = req_tdata[37:32];
   assign req_row          = req_tdata[40:38];
   assign req_first_column = req_tdata[45:41];
   assign req_fmt          = fmt_type'(req_tuser);

   // registers
   state_type              state_ff, state_in;
   fmt_type                fmt_ff, fmt_in;
   logic                   neg_ff, neg_in;
   logic [31:0]            val_ff, val_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [4:0]             cnt_ff, cnt_in;
   logic [5:0]             idx_ff, idx_in;
   logic                   len_zero_ff, len_zero_in;
   logic [5:0]             col_ff, col_in;
   logic [2:0]             row_ff, row_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [14:0]            rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   // control
   logic        req_accept;
   logic        req_row_ok;
   logic        out_free;
   logic        step;
   logic        col_visible;
   logic        char_load;
   logic        char_last;
   logic [6:0]  char_code;
   logic [3:0]  digit;
   logic [5:0]  len_clamped;
   logic [5:0]  len_limit;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_row_ok = (req_row != 3'd0) && ({1'b0, req_row} <= ROW_LIMIT);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // clamp of the digit count by format
   always_comb begin
      case (req_fmt) inside
         FMT_UNSIGNED_DEC, FMT_SIGNED_DEC: len_limit = MAX_DEC_DIGITS;
         FMT_HEX:                          len_limit = MAX_HEX_DIGITS;
         default:                          len_limit = MAX_BIN_DIGITS;
      endcase
      len_clamped = (req_digit_count > len_limit) ? len_limit : req_digit_count;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_row_ok) begin
               if (req_fmt == FMT_UNSIGNED_DEC || req_fmt == FMT_SIGNED_DEC) begin
                  state_in = ST_CONVERT;
               end else if (len_clamped != 6'd0) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_CONVERT: begin
            if (cnt_ff == 5'd31) begin
               if (fmt_ff == FMT_SIGNED_DEC) begin
                  state_in = ST_SIGN;
               end else if (!len_zero_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = len_zero_ff ? ST_IDLE : ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && idx_ff == 6'd0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // character of the current step and whether it reaches the screen
   always_comb begin
      if (fmt_ff == FMT_BIN) begin
         digit = {3'b000, val_ff[idx_ff[4:0]]};
      end else begin
         digit = bcd_ff[{idx_ff[3:0], 2'b00} +: 4];
      end
      col_visible = (col_ff != 6'd0) && (col_ff <= COL_LIMIT);
      step        = 1'b0;
      char_code   = digit_char(digit);
      char_last   = (idx_ff == 6'd0) || (col_ff == COL_LIMIT);
      unique case (state_ff)
         ST_IDLE, ST_CONVERT: begin
            step = 1'b0;
         end
         ST_SIGN: begin
            step      = out_free;
            char_code = neg_ff ? CHAR_MINUS : CHAR_PLUS;
            char_last = len_zero_ff || (col_ff == COL_LIMIT);
         end
         ST_EMIT: begin
            step = out_free;
         end
         default: step = 1'b0;
      endcase
      char_load = step && col_visible;
   end

   // datapath: load, double dabble, emit walk
   always_comb begin
      fmt_in      = fmt_ff;
      neg_in      = neg_ff;
      val_in      = val_ff;
      bcd_in      = bcd_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      len_zero_in = len_zero_ff;
      col_in      = col_ff;
      row_in      = row_ff;

      if (req_accept) begin
         fmt_in      = req_fmt;
         neg_in      = (req_fmt == FMT_SIGNED_DEC) && req_number[31];
         val_in      = ((req_fmt == FMT_SIGNED_DEC) && req_number[31]) ?
                       (~req_number + 32'd1) : req_number;
         bcd_in      = (req_fmt == FMT_HEX) ? {8'h00, req_number} : '0;
         cnt_in      = 5'd0;
         idx_in      = len_clamped - 6'd1;
         len_zero_in = (len_clamped == 6'd0);
         col_in      = {1'b0, req_first_column};
         row_in      = req_row;
      end else if (state_ff == ST_CONVERT) begin
         // one shift-and-add-3 step per cycle, msb of the value first
         for (int k = 0; k < BCD_DIGITS; k++) begin
            bcd_in[4*k +: 4] = (bcd_ff[4*k +: 4] >= 4'd5) ?
                               (bcd_ff[4*k +: 4] + 4'd3) : bcd_ff[4*k +: 4];
         end
         bcd_in = {bcd_in[BCD_WIDTH-2:0], val_ff[31]};
         val_in = {val_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
      end else if (step) begin
         col_in = col_ff + 6'd1;
         if (state_ff == ST_EMIT) begin
            idx_in = idx_ff - 6'd1;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (char_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {char_code, col_ff[4:0], row_ff};
         rsp_last_in  = char_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fmt_ff      <= fmt_in;
      neg_ff      <= neg_in;
      val_ff      <= val_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      len_zero_ff <= len_zero_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // an accepted on-screen transaction with digits takes the sequencer out of idle in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_row_ok && len_clamped != 6'd0) |=> !req_tready)
      else $error("formatter stayed idle after accepting an on-screen transaction");

   // conversion runs all 32 bit steps before anything is emitted
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT && cnt_ff != 5'd31) |=> (state_ff == ST_CONVERT))
      else $error("decimal conversion ended early");

   // a new character never overwrites a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      !(char_load && rsp_valid_ff && !rsp_tready))
      else $error("result register overwritten while stalled");

   // every result lies on a screen row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[2:0] != 3'd0 && {1'b0, rsp_data_ff[2:0]} <= ROW_LIMIT))
      else $error("result row off screen");
`endif

endmodule

[tb/tb.sv]
// testbench for the number to text formatter: directed, stall and random character checks
`timescale 1ns / 100ps

module tb;
   import ntf_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int TEXT_ROWS       = 4;
   localparam int TEXT_COLUMNS    = 16;
   localparam int RESET_CYCLES    = 10;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 200;
   localparam int CYCLE_LIMIT     = 2000000;
   localparam int RANDOM_ITEMS    = 420;
   localparam int MAX_REPORTS     = 10;

   // one character placed on the screen
   typedef struct packed {
      logic [2:0] row;
      logic [4:0] column;
      logic [6:0] code;
      logic       last;
   } screen_char;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // number, digit_count, row, first_column
   logic [1:0]  req_tuser = '0;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // out_row, out_column, char_code
   logic        rsp_tlast;        // last_char

   screen_char  pending_chars[$];
   screen_char  item_chars[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   bit          req_idling = 1'b1;
   bit          rsp_idling = 1'b1;
   bit          rsp_hold_request = 1'b0;

   number_to_text_formatter #(
      .TEXT_ROWS    (TEXT_ROWS),
      .TEXT_COLUMNS (TEXT_COLUMNS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   // gap lengths: mostly short, a few long
   function automatic int unsigned pick_gap(input bit allow_zero);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return allow_zero ? 0 : 1;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("tb: %s", msg);
   endfunction

   // keep a character only when it lands on the screen
   function automatic void place_char(input logic [2:0] row, input int column,
                                      input logic [6:0] code);
      screen_char entry;
      if (row >= 1 && row <= TEXT_ROWS && column >= 1 && column <= TEXT_COLUMNS) begin
         entry.row    = row;
         entry.column = 5'(column);
         entry.code   = code;
         entry.last   = 1'b0;
         item_chars.push_back(entry);
      end
   endfunction

   // characters expected for one request, appended to the pending list
   function automatic void predict_chars(input fmt_type fmt, input logic [31:0] number,
                                         input logic [5:0] digit_count, input logic [2:0] row,
                                         input logic [4:0] first_column);
      logic [31:0]     value;
      longint unsigned wide;
      longint unsigned scale;
      int unsigned     digits;
      int unsigned     i;
      int unsigned     j;
      int              column;
      logic [3:0]      digit;
      value  = number;
      digits = digit_count;
      column = first_column;
      item_chars.delete();

      // sign first, magnitude follows one column later
      if (fmt == FMT_SIGNED_DEC) begin
         if (value[31]) begin
            place_char(row, column, CHAR_MINUS);
            value = ~value + 32'd1;
         end else begin
            place_char(row, column, CHAR_PLUS);
         end
         column++;
      end

      case (fmt)
         FMT_HEX: begin
            if (digits > MAX_HEX_DIGITS) digits = MAX_HEX_DIGITS;
            for (i = 0; i < digits; i++) begin
               digit = value[4 * (digits - 1 - i) +: 4];
               if (digit < 4'd10) place_char(row, column + i, CHAR_ZERO + {3'b000, digit});
               else place_char(row, column + i, CHAR_UPPER_A + {3'b000, digit} - 7'd10);
            end
         end
         FMT_BIN: begin
            if (digits > MAX_BIN_DIGITS) digits = MAX_BIN_DIGITS;
            for (i = 0; i < digits; i++) begin
               place_char(row, column + i, CHAR_ZERO + {6'd0, value[digits - 1 - i]});
            end
         end
         default: begin
            if (digits > MAX_DEC_DIGITS) digits = MAX_DEC_DIGITS;
            wide = value;
            for (i = 0; i < digits; i++) begin
               scale = 1;
               for (j = 0; j < digits - 1 - i; j++) scale = scale * 10;
               digit = 4'((wide / scale) % 10);
               place_char(row, column + i, CHAR_ZERO + {3'b000, digit});
            end
         end
      endcase

      if (item_chars.size() > 0) item_chars[item_chars.size() - 1].last = 1'b1;
      foreach (item_chars[k]) pending_chars.push_back(item_chars[k]);
   endfunction

   // offer one request, predict on acceptance
   task automatic send_item(input fmt_type fmt, input logic [31:0] number,
                            input logic [5:0] digit_count, input logic [2:0] row,
                            input logic [4:0] first_column);
      int unsigned gap;
      gap = req_idling ? pick_gap(1'b1) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, first_column, row, digit_count, number};
      req_tuser  <= fmt;
      do @(posedge clock); while (!req_tready);
      predict_chars(fmt, number, digit_count, row, first_column);
   endtask

   // mostly on-screen requests with sensible digit counts, some noise
   task automatic send_random_item();
      fmt_type     fmt;
      logic [31:0] number;
      logic [5:0]  digit_count;
      logic [2:0]  row;
      logic [4:0]  first_column;
      int unsigned roll;
      int unsigned max_digits;
      fmt  = fmt_type'($urandom_range(0, 3));
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         case ($urandom_range(0, 3))
            0: number = 32'h0000_0000;
            1: number = 32'hFFFF_FFFF;
            2: number = 32'h8000_0000;
            default: number = 32'h7FFF_FFFF;
         endcase
      end else if (roll < 3) begin
         number = $urandom_range(0, 999);
      end else begin
         number = $urandom;
      end
      case (fmt)
         FMT_HEX: max_digits = MAX_HEX_DIGITS;
         FMT_BIN: max_digits = MAX_BIN_DIGITS;
         default: max_digits = MAX_DEC_DIGITS;
      endcase
      if ($urandom_range(0, 99) < 85) digit_count = 6'($urandom_range(0, max_digits));
      else digit_count = 6'($urandom_range(0, 32));
      if ($urandom_range(0, 99) < 85) row = 3'($urandom_range(1, TEXT_ROWS));
      else row = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < 80) first_column = 5'($urandom_range(1, TEXT_COLUMNS));
      else first_column = 5'($urandom_range(0, 31));
      send_item(fmt, number, digit_count, row, first_column);
   endtask

   // sender pauses until every expected character has come
   task automatic wait_all_chars();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_chars.size() != 0);
   endtask

   task automatic test_formats();
      send_item(FMT_UNSIGNED_DEC, 32'hFFFF_FFFF, 6'd10, 3'd1, 5'd1);
      send_item(FMT_UNSIGNED_DEC, 32'h0000_0000, 6'd10, 3'd4, 5'd7);
      send_item(FMT_UNSIGNED_DEC, 32'd123456,    6'd3,  3'd2, 5'd1);
      send_item(FMT_UNSIGNED_DEC, 32'd987654321, 6'd32, 3'd3, 5'd1);
      send_item(FMT_UNSIGNED_DEC, 32'd5,         6'd0,  3'd1, 5'd1);
      send_item(FMT_SIGNED_DEC,   32'h8000_0000, 6'd10, 3'd2, 5'd1);
      send_item(FMT_SIGNED_DEC,   32'h7FFF_FFFF, 6'd10, 3'd3, 5'd1);
      send_item(FMT_SIGNED_DEC,   32'h0000_0000, 6'd0,  3'd1, 5'd5);
      send_item(FMT_SIGNED_DEC,   32'hFFFF_FFFF, 6'd3,  3'd4, 5'd2);
      send_item(FMT_HEX,          32'hFEDC_BA98, 6'd8,  3'd1, 5'd1);
      send_item(FMT_HEX,          32'h0123_4567, 6'd32, 3'd2, 5'd9);
      send_item(FMT_HEX,          32'hDEAD_BEEF, 6'd3,  3'd3, 5'd1);
      send_item(FMT_BIN,          32'hA5A5_A5A5, 6'd32, 3'd1, 5'd1);
      send_item(FMT_BIN,          32'h0000_FFFF, 6'd16, 3'd4, 5'd1);
      wait_all_chars();
   endtask

   // rows and columns off the screen, including requests with no characters
   task automatic test_off_screen();
      send_item(FMT_UNSIGNED_DEC, 32'd4242,      6'd4,  3'd0, 5'd1);
      send_item(FMT_HEX,          32'hCAFE_F00D, 6'd8,  3'd5, 5'd1);
      send_item(FMT_SIGNED_DEC,   32'hFFFF_FF85, 6'd5,  3'd7, 5'd3);
      send_item(FMT_UNSIGNED_DEC, 32'd31415,     6'd5,  3'd2, 5'd0);
      send_item(FMT_BIN,          32'h5555_5555, 6'd32, 3'd3, 5'd31);
      send_item(FMT_SIGNED_DEC,   32'd77,        6'd4,  3'd1, 5'd14);
      send_item(FMT_HEX,          32'h0000_000A, 6'd1,  3'd4, 5'd16);
      send_item(FMT_SIGNED_DEC,   32'h8000_0001, 6'd2,  3'd2, 5'd16);
      wait_all_chars();
   endtask

   // long receiver hold-off while the sender keeps offering back to back
   task automatic test_backpressure();
      req_idling       = 1'b0;
      rsp_hold_request = 1'b1;
      repeat (8) send_random_item();
      wait_all_chars();
      req_idling = 1'b1;
   endtask

   task automatic test_random_items();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // a stretch with no idling on either side
         req_idling = !(n >= 140 && n < 210);
         rsp_idling = req_idling;
         send_random_item();
      end
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      wait_all_chars();
   endtask

   // receiver pacing: random gaps, plus the long hold-off on request
   initial begin : rsp_pacing
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else if (rsp_idling && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (pick_gap(1'b0)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // compare each character transaction with the oldest expectation
   always @(posedge clock) begin : char_check
      screen_char want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_chars.size() == 0) begin
            flag_error($sformatf("unexpected character: tdata=%h tlast=%b",
                                 rsp_tdata, rsp_tlast));
         end else begin
            want = pending_chars.pop_front();
            if (rsp_tdata[2:0] !== want.row)
               flag_error($sformatf("out_row: expected %0d, got %0d", want.row, rsp_tdata[2:0]));
            if (rsp_tdata[7:3] !== want.column)
               flag_error($sformatf("out_column: expected %0d, got %0d",
                                    want.column, rsp_tdata[7:3]));
            if (rsp_tdata[14:8] !== want.code)
               flag_error($sformatf("char_code: expected %h, got %h", want.code, rsp_tdata[14:8]));
            if (rsp_tlast !== want.last)
               flag_error($sformatf("last_char: expected %b, got %b", want.last, rsp_tlast));
         end
      end
   end

   // run limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: done, errors");
      $finish;
   end

   initial begin : main_sequence
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_formats();
      test_off_screen();
      test_backpressure();
      test_random_items();
      // requests with no characters may still be in progress
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

[filelist.f]
src/ntf_pkg.sv
src/number_to_text_formatter.sv
tb/tb.sv
